// ===== hw/rtl/kda_pkg.sv =====
// Shared types and constants for the key debounce and auto-repeat block.
package kda_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MASK_W = 16;
	localparam int COUNT_W = 16;
	localparam int SHORT_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd3;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	localparam logic [SHORT_W-1:0] RESET_DEBOUNCE_TICKS = 8'd10;
	localparam logic [SHORT_W-1:0] RESET_SETTLE_TICKS = 8'd6;
	localparam logic [COUNT_W-1:0] DEFAULT_REPEAT_DELAY = 16'd150;
	localparam logic [COUNT_W-1:0] DEFAULT_REPEAT_PERIOD = 16'd20;

	typedef struct packed {
		logic [SHORT_W-1:0] debounce_ticks;
		logic [SHORT_W-1:0] settle_ticks;
		logic [COUNT_W-1:0] repeat_delay;
		logic [COUNT_W-1:0] repeat_period;
	} kda_cfg_t;

	typedef struct packed {
		logic command;
		logic [MASK_W-1:0] pin_value;
		logic [MASK_W-1:0] key_bits;
	} kda_item_t;

	typedef struct packed {
		logic press_event;
		logic repeat_event;
		logic poll_ignored;
	} kda_result_t;

endpackage

// ===== hw/rtl/kda_if.sv =====
// Handshake interfaces for the command and event channels.
interface kda_cmd_if
	import kda_pkg::*;
();
	logic valid;
	logic ready;
	logic command;
	logic [MASK_W-1:0] pin_value;
	logic [MASK_W-1:0] key_bits;
	modport source(output valid, command, pin_value, key_bits, input ready);
	modport sink(input valid, command, pin_value, key_bits, output ready);
endinterface

interface kda_evt_if;
	logic valid;
	logic ready;
	logic press_event;
	logic repeat_event;
	logic poll_ignored;
	modport source(output valid, press_event, repeat_event, poll_ignored, input ready);
	modport sink(input valid, press_event, repeat_event, poll_ignored, output ready);
endinterface

// ===== hw/rtl/key_debounce_autorepeat_core.sv =====
// Top level of the key debouncer with auto-repeat.
//
//  Channel     Dir  Payload                                      Handshake
//  keys        in   command, pin_value[15:0], key_bits[15:0]     valid/ready
//  events      out  press_event, repeat_event, poll_ignored      valid/ready
//  cfg_*       in   cfg_index[1:0], cfg_data[15:0]               cfg_we strobe
//
// An accepted transaction lands in the input register; the phase logic loads the
// result register once it is empty or its event is being taken, and offers the event.
// One transaction is accepted per cycle while the result side keeps taking events.
// Reset puts the phase to idle, clears countdown, key lock and repeat registers, and
// loads the tick reset values; a stall on events holds the result, then input register.
module key_debounce_autorepeat_core
	import kda_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	kda_cmd_if.sink               keys,
	kda_evt_if.source             events
);

	kda_cfg_t    cfg;
	kda_item_t   item_s1;
	logic        valid_s1;
	kda_result_t res_s2;
	logic        valid_s2;
	kda_result_t step_res;
	logic        advance;

	assign advance = valid_s1 && (!valid_s2 || events.ready);
	assign keys.ready = !valid_s1 || advance;

	kda_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	kda_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keys.ready) begin
			valid_s1 <= keys.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (keys.ready && keys.valid) begin
			item_s1.command <= keys.command;
			item_s1.pin_value <= keys.pin_value;
			item_s1.key_bits <= keys.key_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (events.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign events.valid = valid_s2;
	assign events.press_event = res_s2.press_event;
	assign events.repeat_event = res_s2.repeat_event;
	assign events.poll_ignored = res_s2.poll_ignored;

	// A tick never produces an event of any kind.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command == CMD_TICK |-> step_res == '0)
		else $error("tick transaction produced an event");

	// At most one of the three result flags is set.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> $countones(step_res) <= 1)
		else $error("more than one result flag set");

	// A transaction stuck in the input register keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled input register changed");

endmodule

// ===== hw/rtl/kda_cfg.sv =====
// Configuration register file written through the plain write port.
module kda_cfg
	import kda_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output kda_cfg_t             cfg
);

	kda_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= RESET_DEBOUNCE_TICKS;
			cfg_q.settle_ticks <= RESET_SETTLE_TICKS;
			cfg_q.repeat_delay <= '0;
			cfg_q.repeat_period <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data[SHORT_W-1:0];
				CFG_SETTLE_TICKS: cfg_q.settle_ticks <= cfg_data[SHORT_W-1:0];
				CFG_REPEAT_DELAY: cfg_q.repeat_delay <= cfg_data[COUNT_W-1:0];
				CFG_REPEAT_PERIOD: cfg_q.repeat_period <= cfg_data[COUNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/kda_step.sv =====
// Key phase machine, countdown and key lock, updated once per advancing transaction.
module kda_step
	import kda_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  kda_item_t   item,
	input  kda_cfg_t    cfg,
	output kda_result_t result
);

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_DEBOUNCE = 3'd1,
		PH_SETTLE   = 3'd2,
		PH_WAIT_REP = 3'd3,
		PH_REPEAT   = 3'd4
	} phase_t;

	phase_t              phase_q, phase_nxt;
	logic [COUNT_W-1:0]  count_q, count_nxt;
	logic [MASK_W-1:0]   lock_q, lock_nxt;
	kda_result_t         res;
	logic                pressed;
	logic                expired;
	logic [COUNT_W-1:0]  delay_load;
	logic [COUNT_W-1:0]  period_load;

	assign pressed = (item.pin_value & item.key_bits) != '0;
	assign expired = count_q == '0;
	assign delay_load = (cfg.repeat_delay != '0) ? cfg.repeat_delay : DEFAULT_REPEAT_DELAY;
	assign period_load = (cfg.repeat_period != '0) ? cfg.repeat_period : DEFAULT_REPEAT_PERIOD;

	always_comb begin
		phase_nxt = phase_q;
		count_nxt = count_q;
		lock_nxt = lock_q;
		res = '0;
		if (item.command == CMD_TICK) begin
			if (!expired)
				count_nxt = count_q - COUNT_W'(1);
		end else if (lock_q != '0 && lock_q != item.key_bits) begin
			res.poll_ignored = 1'b1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (pressed) begin
						phase_nxt = PH_DEBOUNCE;
						count_nxt = {{(COUNT_W-SHORT_W){1'b0}}, cfg.debounce_ticks};
					end
				end
				PH_DEBOUNCE: begin
					if (pressed && expired) begin
						phase_nxt = PH_SETTLE;
						count_nxt = {{(COUNT_W-SHORT_W){1'b0}}, cfg.settle_ticks};
						lock_nxt = item.key_bits;
					end
				end
				PH_SETTLE: begin
					if (!pressed) begin
						res.press_event = 1'b1;
						phase_nxt = PH_IDLE;
						lock_nxt = '0;
					end else if (expired) begin
						phase_nxt = PH_WAIT_REP;
						count_nxt = delay_load;
					end
				end
				PH_WAIT_REP: begin
					if (!pressed) begin
						res.press_event = 1'b1;
						phase_nxt = PH_IDLE;
						lock_nxt = '0;
					end else if (expired) begin
						phase_nxt = PH_REPEAT;
					end
				end
				PH_REPEAT: begin
					if (!pressed) begin
						// Release while repeating drops back without an event.
						phase_nxt = PH_IDLE;
						lock_nxt = '0;
					end else if (expired) begin
						count_nxt = period_load;
						res.repeat_event = 1'b1;
					end
				end
				default: begin
					if (!pressed) begin
						phase_nxt = PH_IDLE;
						lock_nxt = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			lock_q <= '0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			count_q <= count_nxt;
			lock_q <= lock_nxt;
		end
	end

	assign result = res;

endmodule
